FILE: rtl/mplt_pkg.sv
// ----------------------------------------------------------------------------
// mplt_pkg: shared types and constants for the peer MAC LRU table
// Item and result layouts, outcome codes and default sizing.
// ----------------------------------------------------------------------------
package mplt_pkg;

  localparam int MAC_W        = 48;
  localparam int FILL_W       = 5;
  localparam int DEF_CAPACITY = 20;

  typedef enum logic [2:0] {
    OUT_UNTRACKED = 3'd0,  // managed MAC, was not in the table
    OUT_REMOVED   = 3'd1,  // managed MAC, dropped from the table
    OUT_MOVED     = 3'd2,  // tracked MAC, moved to the front
    OUT_INSERTED  = 3'd3,  // new MAC, table had room
    OUT_EVICTED   = 3'd4   // new MAC, oldest entry dropped
  } outcome_t;

  typedef struct packed {
    logic [MAC_W-1:0] peer_mac;
    logic             is_enrolled;
    logic             master_valid;
    logic [MAC_W-1:0] master_mac;
  } item_t;

  typedef struct packed {
    outcome_t          outcome;
    logic              evict_valid;
    logic [MAC_W-1:0]  evicted_mac;
    logic [FILL_W-1:0] fill_count;
  } result_t;

endpackage

FILE: rtl/mac_peer_lru_table.sv
// ----------------------------------------------------------------------------
// mac_peer_lru_table: most-recent-first table of peer MAC addresses
// Stream in one registration beat, stream out one outcome beat.
// ----------------------------------------------------------------------------
// Timing: the result waits for the slot walk and then the slot moves, as
//   the single RAM port serves both.
// Throughput: one beat in flight; next input taken the cycle after the result
//   moves into the output register. Reset empties the table (fill count zero,
//   slot contents left as they are); no clearing pass.
// ----------------------------------------------------------------------------
module mac_peer_lru_table
  import mplt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // [47:0] peer_mac, [95:48] master_mac
  input  logic [1:0]  s_axis_tuser,  // [0] is_enrolled, [1] master_valid
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // [47:0] evicted_mac, [52:48] fill_count,
                                     // [55:53] zero
  output logic [3:0]  m_axis_tuser   // [2:0] outcome, [3] evict_valid
);

  item_t            item;
  result_t          res;
  result_t          out_res;
  logic             idle;
  logic             res_valid;
  logic             res_take;
  logic             out_full;
  logic             out_free;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [MAC_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MAC_W-1:0] wr_data;

  // unpack the input beat
  assign item.peer_mac     = s_axis_tdata[47:0];
  assign item.master_mac   = s_axis_tdata[95:48];
  assign item.is_enrolled  = s_axis_tuser[0];
  assign item.master_valid = s_axis_tuser[1];

  // ready only between beats; the output register decouples the far side
  assign s_axis_tready = idle;

  mplt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && s_axis_tready),
    .item      (item),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  mplt_slot_ram #(
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register: takes a finished result when empty or draining
  assign out_free = !out_full || m_axis_tready;
  assign res_take = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_take) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {3'b000, out_res.fill_count, out_res.evicted_mac};
  assign m_axis_tuser  = {out_res.evict_valid, out_res.outcome};

`ifndef SYNTH
  // an accepted beat leaves the input not ready in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // eviction flag and eviction outcome travel together
  a_evict_outcome: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.evict_valid == (out_res.outcome == OUT_EVICTED)))
    else $error("evict flag disagrees with outcome");

  // no evicted MAC without an eviction
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.evict_valid |-> (out_res.evicted_mac == '0))
    else $error("evicted MAC nonzero without eviction");

  // a result is only handed over from the sequencer's done state
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    res_take |=> idle)
    else $error("sequencer not idle after result handoff");
`endif

endmodule

FILE: rtl/mplt_slot_ram.sv
// ----------------------------------------------------------------------------
// mplt_slot_ram: peer slot storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mplt_slot_ram
  import mplt_pkg::*;
#(
  parameter int DEPTH = DEF_CAPACITY,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [MAC_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [MAC_W-1:0] wr_data
);

  logic [MAC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/mplt_ctrl.sv
// ----------------------------------------------------------------------------
// mplt_ctrl: table sequencer
// Walks the slots with one shared MAC compare, then moves entries as needed,
// one per cycle through the RAM port, to close a gap or open the front slot.
// ----------------------------------------------------------------------------
module mplt_ctrl
  import mplt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  item_t            item,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_take,
  output result_t          res,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  logic [MAC_W-1:0] rd_data,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output logic [MAC_W-1:0] wr_data
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_FRONT  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [MAC_W-1:0] mac;
  logic             managed;
  logic [CNT_W-1:0] ridx;
  logic             rd_vld;
  logic [IDX_W-1:0] pidx;
  logic             found;
  logic [IDX_W-1:0] pos;
  logic [MAC_W-1:0] tail;
  logic [CNT_W-1:0] shift_cnt;
  logic [IDX_W-1:0] src;
  logic             dir_up;
  logic             front_pend;
  logic             p_vld;
  logic [IDX_W-1:0] p_dst;

  logic             hit;
  logic             last;
  logic             issue;
  logic             full;
  logic [CNT_W-1:0] ins_n;
  logic             shift_go;

  assign full  = (count == CNT_W'(CAPACITY));
  assign ins_n = full ? count : count + CNT_W'(1);
  assign hit   = rd_vld && (rd_data == mac);
  assign last  = rd_vld && (CNT_W'(pidx) == count - CNT_W'(1));
  assign issue = (state == ST_SEARCH) && (ridx < count) && !hit && !last;
  assign shift_go = (state == ST_SHIFT) && (shift_cnt != '0);

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // single RAM port pair: reads for search and shifts, writes for shifts
  // and the front slot
  always_comb begin
    rd_en   = issue || shift_go;
    rd_addr = shift_go ? src : ridx[IDX_W-1:0];
    wr_en   = p_vld || (state == ST_FRONT);
    wr_addr = (state == ST_FRONT) ? '0 : p_dst;
    wr_data = (state == ST_FRONT) ? mac : rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
      p_vld  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mac     <= item.peer_mac;
            managed <= item.is_enrolled ||
                       (item.master_valid && (item.master_mac == item.peer_mac));
            ridx    <= '0;
            rd_vld  <= 1'b0;
            found   <= 1'b0;
            state   <= (count == '0) ? ST_DECIDE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          pidx   <= ridx[IDX_W-1:0];
          rd_vld <= issue;
          if (issue) begin
            ridx <= ridx + CNT_W'(1);
          end
          if (hit) begin
            found <= 1'b1;
            pos   <= pidx;
            state <= ST_DECIDE;
          end else if (last) begin
            tail  <= rd_data;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          rd_vld          <= 1'b0;
          res.evict_valid <= 1'b0;
          res.evicted_mac <= '0;
          priority if (managed && found) begin
            // close the gap: slot[j] <= slot[j+1]
            res.outcome    <= OUT_REMOVED;
            res.fill_count <= FILL_W'(count - CNT_W'(1));
            count          <= count - CNT_W'(1);
            shift_cnt      <= count - CNT_W'(1) - CNT_W'(pos);
            src            <= pos + IDX_W'(1);
            dir_up         <= 1'b1;
            front_pend     <= 1'b0;
            state          <= ST_SHIFT;
          end else if (managed) begin
            res.outcome    <= OUT_UNTRACKED;
            res.fill_count <= FILL_W'(count);
            state          <= ST_DONE;
          end else if (found) begin
            // slot[j] <= slot[j-1] for j = pos..1, then mac at front
            res.outcome    <= OUT_MOVED;
            res.fill_count <= FILL_W'(count);
            shift_cnt      <= CNT_W'(pos);
            src            <= pos - IDX_W'(1);
            dir_up         <= 1'b0;
            front_pend     <= 1'b1;
            state          <= ST_SHIFT;
          end else begin
            res.outcome     <= full ? OUT_EVICTED : OUT_INSERTED;
            res.evict_valid <= full;
            res.evicted_mac <= full ? tail : '0;
            res.fill_count  <= FILL_W'(ins_n);
            count           <= ins_n;
            shift_cnt       <= ins_n - CNT_W'(1);
            src             <= IDX_W'(ins_n - CNT_W'(2));
            dir_up          <= 1'b0;
            front_pend      <= 1'b1;
            state           <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          p_vld <= shift_go;
          if (shift_go) begin
            p_dst     <= dir_up ? src - IDX_W'(1) : src + IDX_W'(1);
            src       <= dir_up ? src + IDX_W'(1) : src - IDX_W'(1);
            shift_cnt <= shift_cnt - CNT_W'(1);
          end else if (!p_vld) begin
            state <= front_pend ? ST_FRONT : ST_DONE;
          end
        end
        ST_FRONT: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
